FILE: rtl/pccs_pkg.sv
// ============================================================================
// pccs_pkg: shared types and constants of the CDF sampler
// Holds the request and response words, the controller states and the
// command and status groups that pass between controller and datapath.
// ============================================================================
package pccs_pkg;

   // Fixed field widths and Q0.24 constants.
   localparam int FRAC_W     = 24;
   localparam int CFG_W      = 9;
   localparam int WEIGHT_W   = 24;
   localparam int SEED_W     = 25;
   localparam int PROB_W     = 25;
   localparam int DENS_W     = 32;
   localparam int SUM_W      = 32;
   localparam int IDX_W      = 8;
   localparam int DIVIDEND_W = 56;
   localparam int QUOT_W     = 25;

   // Table size; the bin index width above covers exactly this many bins.
   localparam int MAX_BINS   = 256;

   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [SUM_W-1:0]  ONE_FX    = 32'h0100_0000;
   localparam logic [SEED_W-1:0] ONE_SEED  = 25'h100_0000;
   localparam logic [CFG_W-1:0]  BC_RESET  = 9'd256;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   // Request word.
   typedef struct packed {
      logic                cmd;
      logic [WEIGHT_W-1:0] weight;
      logic [SEED_W-1:0]   seed;
   } req_type;

   // Response word.
   typedef struct packed {
      logic              status;
      logic [IDX_W-1:0]  bin_index;
      logic [SEED_W-1:0] sample_position;
      logic [PROB_W-1:0] bin_probability;
      logic [DENS_W-1:0] density;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_NORM_RD,
      ST_NORM_ST,
      ST_NORM_DIV,
      ST_NORM_WR,
      ST_QUERY,
      ST_SRCH,
      ST_SRCH_CMP,
      ST_LO_TAKE,
      ST_HI_TAKE,
      ST_INT_ST,
      ST_INT_DIV,
      ST_POS_ST,
      ST_POS_DIV
   } state_type;

   // Table read address source.
   typedef enum logic [1:0] {
      RD_PTR,
      RD_MID,
      RD_LO,
      RD_HI
   } rd_sel_type;

   // Divider operand selection.
   typedef enum logic [1:0] {
      DIV_NORM,
      DIV_INTERP,
      DIV_POS
   } div_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       load_step;
      logic       norm_write;
      logic       set_ready;
      logic       srch_init;
      logic       srch_upd;
      logic       take_c0;
      logic       take_w;
      logic       take_d;
      logic       div_start;
      logic       respond;
      logic       respond_nr;
      div_op_type div_op;
      rd_sel_type rd_sel;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_query;
      logic table_ready;
      logic load_last;
      logic norm_last;
      logic srch_done;
      logic w_zero;
      logic div_done;
   } stat_type;

endpackage

FILE: rtl/pccs_div.sv
// ============================================================================
// pccs_div: serial restoring divider
// Produces a 25-bit quotient of a 56-bit dividend by a 32-bit divisor, one
// quotient bit per cycle. The quotient must fit in 25 bits.
// ============================================================================
module pccs_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pccs_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [pccs_pkg::SUM_W-1:0]      divisor,
   output logic [pccs_pkg::QUOT_W-1:0]     quot,
   output logic                            done
);
   import pccs_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [SUM_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [SUM_W:0]    trial;
   logic              ge;

   // One trial subtraction per cycle; the quotient shifts in from the bottom.
   always_comb begin
      trial   = {rem_ff, q_ff[QUOT_W-1]};
      ge      = (trial >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, dividend[DIVIDEND_W-1:QUOT_W]};
         q_in   = dividend[QUOT_W-1:0];
         dvs_in = divisor;
         cnt_in = CNT_W'(QUOT_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? SUM_W'(trial - {1'b0, dvs_ff}) : trial[SUM_W-1:0];
         q_in   = {q_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

FILE: rtl/pccs_ctrl.sv
// ============================================================================
// pccs_ctrl: sequencing state machine
// Steps through weight loads, table normalization and sample queries and
// issues commands to the datapath.
// ============================================================================
module pccs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pccs_pkg::stat_type  stat,
   output pccs_pkg::ctrl_type  ctrl,
   output logic                busy,
   output logic                idle
);
   import pccs_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = stat.is_query ? ST_QUERY : ST_LOAD;
         end
         ST_LOAD:     state_in = stat.load_last ? ST_NORM_RD : ST_IDLE;
         ST_NORM_RD:  state_in = ST_NORM_ST;
         ST_NORM_ST:  state_in = ST_NORM_DIV;
         ST_NORM_DIV: begin
            if (stat.div_done) state_in = ST_NORM_WR;
         end
         ST_NORM_WR:  state_in = stat.norm_last ? ST_IDLE : ST_NORM_RD;
         ST_QUERY:    state_in = stat.table_ready ? ST_SRCH : ST_IDLE;
         ST_SRCH:     state_in = stat.srch_done ? ST_LO_TAKE : ST_SRCH_CMP;
         ST_SRCH_CMP: state_in = ST_SRCH;
         ST_LO_TAKE:  state_in = ST_HI_TAKE;
         ST_HI_TAKE:  state_in = ST_INT_ST;
         ST_INT_ST:   state_in = stat.w_zero ? ST_POS_ST : ST_INT_DIV;
         ST_INT_DIV: begin
            if (stat.div_done) state_in = ST_POS_ST;
         end
         ST_POS_ST:   state_in = ST_POS_DIV;
         ST_POS_DIV: begin
            if (stat.div_done) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      ctrl        = '0;
      ctrl.div_op = DIV_NORM;
      ctrl.rd_sel = RD_PTR;
      unique case (state_ff)
         ST_IDLE:     ctrl.capture = start;
         ST_LOAD:     ctrl.load_step = 1'b1;
         ST_NORM_RD:  ctrl.rd_sel = RD_PTR;
         ST_NORM_ST: begin
            ctrl.div_start = 1'b1;
            ctrl.div_op    = DIV_NORM;
         end
         ST_NORM_DIV: ctrl.div_op = DIV_NORM;
         ST_NORM_WR: begin
            ctrl.norm_write = 1'b1;
            ctrl.set_ready  = stat.norm_last;
         end
         ST_QUERY: begin
            ctrl.srch_init  = stat.table_ready;
            ctrl.respond_nr = ~stat.table_ready;
         end
         ST_SRCH:     ctrl.rd_sel = stat.srch_done ? RD_LO : RD_MID;
         ST_SRCH_CMP: ctrl.srch_upd = 1'b1;
         ST_LO_TAKE: begin
            ctrl.take_c0 = 1'b1;
            ctrl.rd_sel  = RD_HI;
         end
         ST_HI_TAKE:  ctrl.take_w = 1'b1;
         ST_INT_ST: begin
            ctrl.take_d    = stat.w_zero;
            ctrl.div_start = ~stat.w_zero;
            ctrl.div_op    = DIV_INTERP;
         end
         ST_INT_DIV:  ctrl.take_d = stat.div_done;
         ST_POS_ST: begin
            ctrl.div_start = 1'b1;
            ctrl.div_op    = DIV_POS;
         end
         ST_POS_DIV:  ctrl.respond = stat.div_done;
         default:     ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign idle = (state_ff == ST_IDLE);

endmodule

FILE: rtl/pccs_dpath.sv
// ============================================================================
// pccs_dpath: CDF table, search registers and arithmetic
// Keeps the prefix-sum / CDF memory, the running sum, the binary search
// bounds and the response register, and drives the shared serial divider.
// ============================================================================
module pccs_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  pccs_pkg::req_type          req_data,
   input  logic                       csr_we,
   input  logic [pccs_pkg::CFG_W-1:0] csr_data,
   input  pccs_pkg::ctrl_type         ctrl,
   output pccs_pkg::stat_type         stat,
   output pccs_pkg::rsp_type          rsp_data,
   output logic                       rsp_strobe
);
   import pccs_pkg::*;

   localparam int AW     = $clog2(MAX_BINS + 1);
   localparam int DEPTH  = MAX_BINS + 1;
   localparam int PROD_W = PROB_W + CFG_W;

   // CDF memory; entry zero always reads as zero and is never written.
   logic [SUM_W-1:0] mem [DEPTH];

   logic [CFG_W-1:0]  bc_ff, bc_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [AW-1:0]     count_ff, count_in;
   logic              ready_ff, ready_in;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [SEED_W-1:0] seed_ff;
   logic [AW-1:0]     ptr_ff;
   logic [AW-1:0]     lo_ff, hi_ff;
   logic [SEED_W-1:0] c0_ff, r_ff, d_ff;
   logic [PROB_W-1:0] w_ff;
   logic              wz_ff;
   logic [DENS_W-1:0] dens_ff;
   logic [SUM_W-1:0]  rdata_ff;
   logic              rzero_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic [CFG_W-1:0]  n;
   logic [AW-1:0]     n_a;
   logic              need_clr;
   logic [SUM_W:0]    sum_ext;
   logic [SUM_W-1:0]  new_sum;
   logic [AW-1:0]     new_count;
   logic [AW:0]       mid_w;
   logic [AW-1:0]     mid;
   logic [AW-1:0]     raddr;
   logic [SUM_W-1:0]  rvalue;
   logic              mem_we;
   logic [AW-1:0]     waddr;
   logic [SUM_W-1:0]  wdata;
   logic [SUM_W-1:0]  wdiff;
   logic [PROB_W-1:0] w_new;
   logic [PROD_W-1:0] prod;
   logic [DIVIDEND_W-1:0] dividend;
   logic [SUM_W-1:0]  divisor;
   logic [QUOT_W-1:0] quot;
   logic              div_done;
   logic [SEED_W-1:0] pos;

   // Bins in use: at least one, at most the table size.
   always_comb begin
      priority if (bc_ff == '0) n = CFG_W'(1);
      else if (int'(bc_ff) > MAX_BINS) n = CFG_W'(MAX_BINS);
      else n = bc_ff;
   end
   assign n_a = AW'(n);

   // Load step: restart when the table is complete, then add with saturation.
   assign need_clr  = ready_ff || (count_ff >= n_a);
   assign sum_ext   = {1'b0, (need_clr ? '0 : sum_ff)} + (SUM_W + 1)'(weight_ff);
   assign new_sum   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
   assign new_count = (need_clr ? '0 : count_ff) + AW'(1);

   always_comb begin
      bc_in    = bc_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      ready_in = ready_ff;
      if (csr_we) begin
         bc_in    = csr_data;
         sum_in   = '0;
         count_in = '0;
         ready_in = 1'b0;
      end else if (ctrl.load_step) begin
         sum_in   = new_sum;
         count_in = new_count;
         ready_in = 1'b0;
      end else if (ctrl.set_ready) begin
         ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff    <= BC_RESET;
         sum_ff   <= '0;
         count_ff <= '0;
         ready_ff <= 1'b0;
      end else begin
         bc_ff    <= bc_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ready_ff <= ready_in;
      end
   end

   // Read address and midpoint of the search window.
   assign mid_w = ({1'b0, lo_ff} + {1'b0, hi_ff} + (AW + 1)'(1)) >> 1;
   assign mid   = mid_w[AW-1:0];

   always_comb begin
      unique case (ctrl.rd_sel)
         RD_PTR:  raddr = ptr_ff;
         RD_MID:  raddr = mid;
         RD_LO:   raddr = lo_ff;
         RD_HI:   raddr = lo_ff + AW'(1);
         default: raddr = ptr_ff;
      endcase
   end

   // Write port: prefix sums while loading, CDF values while normalizing.
   always_comb begin
      mem_we = ctrl.load_step | ctrl.norm_write;
      waddr  = ctrl.load_step ? new_count : ptr_ff;
      if (ctrl.load_step) wdata = new_sum;
      else if (ptr_ff == n_a) wdata = ONE_FX;
      else wdata = SUM_W'(quot);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
      rzero_ff <= (raddr == '0);
   end

   assign rvalue = rzero_ff ? '0 : rdata_ff;

   // Divider operands.
   always_comb begin
      unique case (ctrl.div_op)
         DIV_NORM: begin
            if (sum_ff != '0) begin
               dividend = DIVIDEND_W'(rvalue) << FRAC_W;
               divisor  = sum_ff;
            end else begin
               dividend = DIVIDEND_W'(ptr_ff) << FRAC_W;
               divisor  = SUM_W'(n);
            end
         end
         DIV_INTERP: begin
            dividend = DIVIDEND_W'(r_ff) << FRAC_W;
            divisor  = SUM_W'(w_ff);
         end
         DIV_POS: begin
            dividend = (DIVIDEND_W'(lo_ff) << FRAC_W) + DIVIDEND_W'(d_ff);
            divisor  = SUM_W'(n);
         end
         default: begin
            dividend = '0;
            divisor  = SUM_W'(n);
         end
      endcase
   end

   pccs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quot     (quot),
      .done     (div_done)
   );

   // Bin width from two neighboring CDF entries.
   assign wdiff = rvalue - SUM_W'(c0_ff);
   assign w_new = (rvalue < SUM_W'(c0_ff)) ? '0 : wdiff[PROB_W-1:0];
   assign prod  = PROD_W'(w_ff) * PROD_W'(n);
   assign pos   = (quot > ONE_SEED) ? ONE_SEED : quot;

   // Request capture, normalization pointer and query registers.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         weight_ff <= req_data.weight;
         seed_ff   <= (req_data.seed > ONE_SEED) ? ONE_SEED : req_data.seed;
      end
      if (ctrl.load_step) ptr_ff <= AW'(1);
      else if (ctrl.norm_write) ptr_ff <= ptr_ff + AW'(1);
      if (ctrl.srch_init) begin
         lo_ff <= '0;
         hi_ff <= n_a - AW'(1);
      end else if (ctrl.srch_upd) begin
         if (rvalue <= SUM_W'(seed_ff)) lo_ff <= mid;
         else hi_ff <= mid - AW'(1);
      end
      if (ctrl.take_c0) c0_ff <= rvalue[SEED_W-1:0];
      if (ctrl.take_w) begin
         w_ff  <= w_new;
         wz_ff <= (w_new == '0);
         r_ff  <= seed_ff - c0_ff;
      end
      if (ctrl.take_d) begin
         d_ff    <= wz_ff ? r_ff : quot;
         dens_ff <= (prod > PROD_W'(SUM_MAX)) ? SUM_MAX : prod[DENS_W-1:0];
      end
      if (ctrl.respond) begin
         rsp_ff.status          <= STATUS_OK;
         rsp_ff.bin_index       <= IDX_W'(lo_ff);
         rsp_ff.sample_position <= pos;
         rsp_ff.bin_probability <= w_ff;
         rsp_ff.density         <= dens_ff;
      end else if (ctrl.respond_nr) begin
         rsp_ff <= rsp_type'{status: STATUS_NOT_READY, default: '0};
      end
   end

   // Response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.respond | ctrl.respond_nr;
      end
   end

   always_comb begin
      stat.is_query    = (req_data.cmd == CMD_QUERY);
      stat.table_ready = ready_ff;
      stat.load_last   = (new_count == n_a);
      stat.norm_last   = (ptr_ff == n_a);
      stat.srch_done   = (lo_ff == hi_ff);
      stat.w_zero      = wz_ff;
      stat.div_done    = div_done;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_valid_ff;

endmodule

FILE: rtl/piecewise_constant_cdf_sampler.sv
// ============================================================================
// piecewise_constant_cdf_sampler: piecewise-constant distribution sampler
// Loads bin weights, normalizes their prefix sums into a Q0.24 CDF and
// answers sample queries with bin, position, probability and density.
// ============================================================================
//
//   channel   ports                       handshake
//   request   start, busy, req_data       word taken when start and not busy
//   response  rsp_strobe, rsp_data        word valid for one cycle, no stall
//   config    csr_valid, csr_ready,       word taken when valid and ready
//             csr_data
//
// A weight load is captured in idle and written in the load state. The last
// load also normalizes the table, bin by bin, through the shared 25-step
// serial divider. A query runs a binary search with one registered memory
// read per step, then two serial divisions; an empty bin skips the first
// division. A query before the table is complete answers not-ready.
// Reset is synchronous; afterward bin_count is 256 and the table is empty.
// The response side cannot stall; configuration is accepted only when idle.
module piecewise_constant_cdf_sampler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  pccs_pkg::req_type          req_data,
   output logic                       rsp_strobe,
   output pccs_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pccs_pkg::CFG_W-1:0] csr_data
);
   import pccs_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic     idle;
   logic     csr_we;

   assign csr_ready = idle;
   assign csr_we    = csr_valid & idle;

   pccs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy),
      .idle  (idle)
   );

   pccs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_data   (csr_data),
      .ctrl       (ctrl),
      .stat       (stat),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule
